### hw/rtl/lzw_pkg.sv
// Shared widths for the LZW string compressor.
package lzw_pkg;
  localparam int CHAR_W = 8;
  localparam int CODE_W = 6;
endpackage

### hw/rtl/lzw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/lzw_string_compressor_unit.sv
// Top level of the LZW string compressor: byte buffer, dictionary and sequencer.
//
// The block collects a string one byte per transaction (one cycle each) until a
// transaction with last set; bytes past MAX_LEN are dropped and flagged as
// truncated. It then seeds the dictionary with the distinct bytes in order of
// first appearance (codes 1 up), runs LZW over the buffer and sends one code
// per matched phrase (code 0 for a byte with no dictionary entry), last_code
// marking the final one. Every dictionary lookup scans the stored entries one
// per cycle through the dictionary RAM read port. The first lookup of a byte
// passes through buffer fetch, load, scan and decide; a second lookup for the
// root of the byte, needed when a phrase ends in the compression pass, repeats
// the scan. The seeding pass does one lookup per byte. Processing can also be
// held while the consumer stalls the output. No new string is taken until every
// code of the previous one has left the sequencer; the final code may still
// sit in the output register while the next string loads.
// Codes are dictionary indexes masked to 6 bits.
module lzw_string_compressor_unit
  import lzw_pkg::*;
#(
  parameter int MAX_LEN   = 32,
  parameter int DICT_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              valid,
  output logic              stall,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              last,
  // output channel
  output logic              code_valid,
  input  logic              code_stall,
  output logic [CODE_W-1:0] code,
  output logic              last_code,
  output logic              truncated
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(DICT_SIZE);
  localparam int DW = CW + CHAR_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]        state;
  logic              phase;      // 0: seeding, 1: compressing
  logic              step;       // second lookup of a byte (root of the byte)
  logic [AW-1:0]     idx;
  logic [LW-1:0]     len;
  logic              ovf;
  logic [CW-1:0]     ecnt;
  logic [CW-1:0]     cur;
  logic [CHAR_W-1:0] cbyte;
  logic [CW-1:0]     tgt;
  logic [CW-1:0]     k;
  logic [CW-1:0]     rk;
  logic              spend;
  logic              fnd;
  logic [CW-1:0]     fcode;
  logic [LW-1:0]     n;
  logic              pend_valid;
  logic [CW-1:0]     pend_code;

  // buffer RAM
  logic              buf_we;
  logic [CHAR_W-1:0] buf_rdata;
  // dictionary RAM
  logic              dict_we;
  logic [CW-1:0]     dict_waddr;
  logic [DW-1:0]     dict_wdata;
  logic [DW-1:0]     dict_rdata;

  // sequencer helpers
  logic              in_acc;
  logic              out_free;
  logic              emit_req;
  logic [CW-1:0]     emit_val;
  logic              emit_ok;
  logic              blocked;
  logic              push;
  logic              push_last;
  logic              add_req;
  logic [CW-1:0]     add_prefix;
  logic              last_byte;
  logic              room;

  assign stall     = (state != S_IDLE);
  assign in_acc    = valid && !stall;
  assign out_free  = !code_valid || !code_stall;
  assign last_byte = (idx == AW'(len - LW'(1)));
  assign room      = (ecnt < CW'(DICT_SIZE - 1));
  assign buf_we    = in_acc && (len < LW'(MAX_LEN));

  lzw_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (len[AW-1:0]),
    .wdata (in_char),
    .raddr (idx),
    .rdata (buf_rdata)
  );

  lzw_ram #(.WIDTH(DW), .DEPTH(DICT_SIZE)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .raddr (k),
    .rdata (dict_rdata)
  );

  // Emission and dictionary-add requests of the decision states.
  always_comb begin
    emit_req   = 1'b0;
    emit_val   = '0;
    add_req    = 1'b0;
    add_prefix = '0;
    push_last  = 1'b0;
    if (state == S_DEC) begin
      if (!phase) begin
        add_req = !fnd;
      end else if (!step) begin
        if (!fnd) begin
          emit_req   = 1'b1;
          emit_val   = cur;
          add_req    = (cur != '0);
          add_prefix = cur;
        end
      end else begin
        emit_req = !fnd;
      end
    end else if (state == S_FINAL) begin
      emit_req = (cur != '0);
      emit_val = cur;
    end
    emit_ok = emit_req && (n < LW'(MAX_LEN));
    blocked = emit_ok && pend_valid && !out_free;
    push    = emit_ok && pend_valid && out_free;
    if (state == S_FLUSH) begin
      blocked   = pend_valid && !out_free;
      push      = pend_valid && out_free;
      push_last = 1'b1;
    end
    dict_we    = add_req && room && !blocked;
    dict_waddr = ecnt + CW'(1);
    dict_wdata = {add_prefix, cbyte};
  end

  // Output register: holds one code while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (push) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
    if (push) begin
      code      <= CODE_W'(pend_code);
      last_code <= push_last;
      truncated <= ovf;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= 1'b0;
      step       <= 1'b0;
      idx        <= '0;
      len        <= '0;
      ovf        <= 1'b0;
      ecnt       <= '0;
      cur        <= '0;
      k          <= '0;
      spend      <= 1'b0;
      fnd        <= 1'b0;
      n          <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (dict_we) begin
        ecnt <= ecnt + CW'(1);
      end
      if (emit_ok && !blocked) begin
        pend_valid <= 1'b1;
        pend_code  <= emit_val;
        n          <= n + LW'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (len < LW'(MAX_LEN)) begin
              len <= len + LW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              state <= S_FETCH;
              phase <= 1'b0;
              idx   <= '0;
              ecnt  <= '0;
              cur   <= '0;
            end
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          cbyte <= buf_rdata;
          tgt   <= phase ? cur : '0;
          step  <= 1'b0;
          k     <= CW'(1);
          spend <= 1'b0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          // one entry per cycle: issue k, compare the entry issued last cycle
          if (spend && dict_rdata == {tgt, cbyte}) begin
            fnd   <= 1'b1;
            fcode <= rk;
            state <= S_DEC;
          end else if (ecnt == '0 || (spend && rk == ecnt)) begin
            fnd   <= 1'b0;
            state <= S_DEC;
          end else begin
            k     <= k + CW'(1);
            rk    <= k;
            spend <= 1'b1;
          end
        end
        S_DEC: begin
          if (!blocked) begin
            if (phase && !step && !fnd && cur != '0) begin
              // phrase ended: restart from the root of this byte
              step  <= 1'b1;
              tgt   <= '0;
              k     <= CW'(1);
              spend <= 1'b0;
              state <= S_SRCH;
            end else begin
              if (phase) begin
                cur <= fnd ? fcode : '0;
              end
              if (last_byte) begin
                if (phase) begin
                  state <= S_FINAL;
                end else begin
                  phase <= 1'b1;
                  idx   <= '0;
                  cur   <= '0;
                  state <= S_FETCH;
                end
              end else begin
                idx   <= idx + AW'(1);
                state <= S_FETCH;
              end
            end
          end
        end
        S_FINAL: begin
          if (!blocked) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!blocked) begin
            pend_valid <= 1'b0;
            len        <= '0;
            ovf        <= 1'b0;
            ecnt       <= '0;
            cur        <= '0;
            n          <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Emit count never passes the result limit.
  a_n_bound: assert property (@(posedge clk) disable iff (rst)
    n <= LW'(MAX_LEN))
    else $error("emit count over limit");

  // No code is pending while a new string is being loaded.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!pend_valid && ecnt == '0))
    else $error("stale state in idle");

  // Dictionary is written only during processing and never at code zero.
  a_dict_wr: assert property (@(posedge clk) disable iff (rst)
    dict_we |-> (state == S_DEC && dict_waddr != '0))
    else $error("bad dictionary write");

  // A push only happens when the output register can take it.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("output overwritten");
endmodule

### test/tb_top.sv
// Testbench for the LZW string compressor: directed table, an overflowing string and random strings.
module tb_top;
  import lzw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN   = 32;
  localparam int DICT_SIZE = 64;
  // watchdog on cycles with no transfer: covers the worst string plus long receiver hold-off
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last_code;
    logic              truncated;
  } code_rec_t;

  // one directed row; exp_n = 0 means predictor only
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              lst;
    int                exp_n;
    logic [CODE_W-1:0] exp_code;
    logic              exp_trunc;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic [CHAR_W-1:0] in_char = '0;
  logic last = 1'b0;
  logic code_valid;
  logic code_stall = 1'b0;
  logic [CODE_W-1:0] code;
  logic last_code;
  logic truncated;

  lzw_string_compressor_unit #(.MAX_LEN(MAX_LEN), .DICT_SIZE(DICT_SIZE)) dut (
    .clk(clk), .rst(rst),
    .valid(valid), .stall(stall), .in_char(in_char), .last(last),
    .code_valid(code_valid), .code_stall(code_stall),
    .code(code), .last_code(last_code), .truncated(truncated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: the string being gathered.
  logic [CHAR_W-1:0] str_bytes[MAX_LEN];
  int                str_len = 0;
  logic              str_dropped = 1'b0;
  code_rec_t         expected_codes[$];
  int                mismatches = 0;
  bit                timed_out = 1'b0;
  bit                sending_done = 1'b0;
  int                idle_cycles = 0;
  bit                hold_off = 1'b0;

  // Run LZW over the gathered string and queue the codes it yields.
  function automatic void compress_string();
    int         pfx[DICT_SIZE];
    logic [7:0] byt[DICT_SIZE];
    int         n_entries = 0;
    int         phrase = 0;
    int         hit;
    code_rec_t  outq[$];
    code_rec_t  r;
    // lookup is done by the find_code helper below
    for (int i = 0; i < str_len; i++) begin
      hit = find_code(pfx, byt, n_entries, 0, str_bytes[i]);
      if (hit == 0 && n_entries + 1 < DICT_SIZE) begin
        n_entries++;
        pfx[n_entries] = 0;
        byt[n_entries] = str_bytes[i];
      end
    end
    for (int i = 0; i < str_len; i++) begin
      hit = find_code(pfx, byt, n_entries, phrase, str_bytes[i]);
      if (hit != 0) begin
        phrase = hit;
      end else if (phrase != 0) begin
        r = '{code: phrase[CODE_W-1:0], last_code: 1'b0, truncated: str_dropped};
        outq.push_back(r);
        if (n_entries + 1 < DICT_SIZE) begin
          n_entries++;
          pfx[n_entries] = phrase;
          byt[n_entries] = str_bytes[i];
        end
        phrase = find_code(pfx, byt, n_entries, 0, str_bytes[i]);
        if (phrase == 0) begin
          r = '{code: '0, last_code: 1'b0, truncated: str_dropped};
          outq.push_back(r);
        end
      end else begin
        r = '{code: '0, last_code: 1'b0, truncated: str_dropped};
        outq.push_back(r);
      end
    end
    if (phrase != 0) begin
      r = '{code: phrase[CODE_W-1:0], last_code: 1'b0, truncated: str_dropped};
      outq.push_back(r);
    end
    while (outq.size() > MAX_LEN) void'(outq.pop_back());
    if (outq.size() > 0) outq[outq.size()-1].last_code = 1'b1;
    foreach (outq[k]) expected_codes.push_back(outq[k]);
  endfunction

  function automatic int find_code(int pfx[DICT_SIZE], logic [7:0] byt[DICT_SIZE],
                                   int n_entries, int prefix, logic [7:0] b);
    for (int k = 1; k <= n_entries && k < DICT_SIZE; k++) begin
      if (pfx[k] == prefix && byt[k] == b) return k;
    end
    return 0;
  endfunction

  // Apply one accepted byte to the predictor.
  function automatic void accept_byte(logic [CHAR_W-1:0] ch, logic lst);
    if (str_len < MAX_LEN) begin
      str_bytes[str_len] = ch;
      str_len++;
    end else begin
      str_dropped = 1'b1;
    end
    if (lst) begin
      compress_string();
      str_len = 0;
      str_dropped = 1'b0;
    end
  endfunction

  // Offer one transaction after a random gap (none if no_gap); returns once accepted.
  // valid stays high on return so back-to-back bytes need no extra edge.
  task automatic send_byte(logic [CHAR_W-1:0] ch, logic lst, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid   <= 1'b1;
    in_char <= ch;
    last    <= lst;
    do @(posedge clk); while (stall);
    accept_byte(ch, lst);
  endtask

  // Directed table: hand-written first code for rows easy to read off.
  stim_row_t dir_rows[$];
  initial begin
    dir_rows.push_back('{8'hFF, 1'b1, 1, 6'd1, 1'b0});  // single max byte
    dir_rows.push_back('{8'h01, 1'b1, 1, 6'd1, 1'b0});  // single byte 0x01
    dir_rows.push_back('{8'h00, 1'b1, 1, 6'd1, 1'b0});  // zero byte is ordinary
    dir_rows.push_back('{8'h41, 1'b0, 0, 6'd0, 1'b0});  // repeated phrase "AAAA"
    dir_rows.push_back('{8'h41, 1'b0, 0, 6'd0, 1'b0});
    dir_rows.push_back('{8'h41, 1'b0, 0, 6'd0, 1'b0});
    dir_rows.push_back('{8'h41, 1'b1, 0, 6'd0, 1'b0});
    dir_rows.push_back('{8'hAA, 1'b0, 0, 6'd0, 1'b0});  // "ab ab" pattern
    dir_rows.push_back('{8'h55, 1'b0, 0, 6'd0, 1'b0});
    dir_rows.push_back('{8'hAA, 1'b0, 0, 6'd0, 1'b0});
    dir_rows.push_back('{8'h55, 1'b1, 0, 6'd0, 1'b0});
  end

  // Sender: directed rows, an overflowing string, then random strings.
  initial begin
    int n_items;
    int slen;
    logic [CHAR_W-1:0] alpha[4];
    logic [CHAR_W-1:0] ch;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].ch, dir_rows[i].lst, 1'b0);
      if (dir_rows[i].exp_n != 0) begin
        // typed-in expectation replaces the predictor for this row
        void'(expected_codes.pop_back());
        expected_codes.push_back('{code: dir_rows[i].exp_code, last_code: 1'b1,
                                   truncated: dir_rows[i].exp_trunc});
      end
    end
    // buffer overflow: 34 distinct bytes, last two dropped, truncated set
    for (int i = 0; i < MAX_LEN + 2; i++)
      send_byte(8'(i * 7 + 3), i == MAX_LEN + 1, 1'b0);
    // random strings: mostly small alphabets to grow long phrases
    n_items = 0;
    while (n_items < 125) begin
      slen = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LEN, MAX_LEN + 3)
                                         : $urandom_range(1, 12);
      foreach (alpha[k]) alpha[k] = 8'($urandom);
      for (int i = 0; i < slen; i++) begin
        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 3)];
        send_byte(ch, i == slen - 1, $urandom_range(0, 3) == 0);
        n_items++;
      end
    end
    valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver stall: random 0..6 per code, one long hold-off early on.
  initial begin
    int gap;
    code_stall <= 1'b1;
    @(negedge rst);
    repeat (300) @(posedge clk);   // long hold-off while bytes keep coming
    forever begin
      code_stall <= 1'b0;
      do @(posedge clk); while (!code_valid);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        code_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Checker and watchdog.
  always @(posedge clk) begin
    code_rec_t want;
    if (!rst) begin
      if ((valid && !stall) || (code_valid && !code_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (code_valid && !code_stall) begin
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected code %0d", code);
        end else begin
          want = expected_codes.pop_front();
          if (want.code !== code || want.last_code !== last_code ||
              want.truncated !== truncated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("code mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                       want.code, want.last_code, want.truncated,
                       code, last_code, truncated);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  // End of run.
  initial begin
    wait (timed_out || (sending_done && expected_codes.size() == 0));
    if (!timed_out) repeat (200) @(posedge clk);
    if (!timed_out && mismatches == 0 && expected_codes.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
